FILE: rtl/sdft_pkg.sv
// Shared types, constants and elaboration-time twiddle generation for the
// sliding DFT bin tracker. No dependencies.
package sdft_pkg;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  localparam logic [1:0] REG_STABILITY = 2'd0;
  localparam logic [1:0] REG_RISE      = 2'd1;
  localparam logic [1:0] REG_FALL      = 2'd2;
  localparam logic [1:0] REG_DECAY     = 2'd3;

  localparam logic [15:0] RST_STABILITY = 16'd65470;
  localparam logic [15:0] RST_RISE      = 16'd66;
  localparam logic [15:0] RST_FALL      = 16'd655;
  localparam logic [15:0] RST_DECAY     = 16'd65208;

  typedef struct packed {
    logic [15:0] stability;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [15:0] decay;
  } sdft_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [16:0] diff;
  } sdft_queue_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_ROUND, ST_ROT, ST_SAT,
    ST_SQUARE, ST_SUM, ST_ROOT, ST_TRACK, ST_EMIT
  } sdft_state_t;

  // shift-subtract division, elaboration use only
  function automatic longint unsigned sdft_udiv(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // signed division truncating towards zero
  function automatic longint sdft_sdiv(longint a, longint unsigned b);
    longint unsigned ua;
    longint unsigned uq;
    ua = (a < 0) ? longint'(-a) : longint'(a);
    uq = sdft_udiv(ua, b);
    return (a < 0) ? -longint'(uq) : longint'(uq);
  endfunction

  function automatic logic signed [15:0] sdft_to_q15(longint q30);
    longint v;
    v = (q30 + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    if (v < -64'sd32768) v = -64'sd32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] sdft_twiddle(int unsigned k, int unsigned n,
                                                      logic want_sin);
    longint unsigned num;
    longint unsigned quarter;
    longint x, x2, ts, tc, sn, cs, oc, os;
    num = 64'(4 * k);
    quarter = 0;
    for (int i = 0; i < 4; i++) begin
      if (num >= 64'(n)) begin
        num = num - 64'(n);
        quarter = quarter + 1;
      end
    end
    x  = sdft_sdiv(Q30_HALF_PI * longint'(num), 64'(n));
    x2 = (x * x) >>> 30;
    ts = Q30_ONE;
    tc = Q30_ONE;
    for (int m = 13; m >= 3; m -= 2)
      ts = Q30_ONE - sdft_sdiv((x2 * ts) >>> 30, 64'(m * (m - 1)));
    for (int m = 14; m >= 2; m -= 2)
      tc = Q30_ONE - sdft_sdiv((x2 * tc) >>> 30, 64'(m * (m - 1)));
    sn = (x * ts) >>> 30;
    cs = tc;
    unique case (quarter[1:0])
      2'd0: begin oc = cs;  os = sn;  end
      2'd1: begin oc = -sn; os = cs;  end
      2'd2: begin oc = -cs; os = -sn; end
      default: begin oc = sn; os = -cs; end
    endcase
    return want_sin ? sdft_to_q15(os) : sdft_to_q15(oc);
  endfunction

  function automatic logic signed [31:0] sdft_sat32(logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7fffffff;
    if (v < -51'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

FILE: rtl/sdft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/sdft_front.sv
// Front end: takes samples, keeps the delay line and queues the input
// difference for the bin engine. Depends on sdft_pkg and sdft_ram.
module sdft_front import sdft_pkg::*; #(
  parameter int WINDOW_LENGTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] sample,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               pop,
  output sdft_queue_t        head
);
  localparam int AW = $clog2(WINDOW_LENGTH);

  logic [AW-1:0]            pos;
  logic [WINDOW_LENGTH-1:0] dl_valid;
  logic                     pend;
  logic [15:0]              x_r;
  logic [15:0]              rdata;
  logic [15:0]              old;
  logic [16:0]              d;
  logic [16:0]              q0, q1;
  logic [1:0]               count;
  logic                     accept;

  assign in_stall = pend || (count == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign old      = dl_valid[pos] ? rdata : 16'd0;
  assign d        = 17'($signed({x_r[15], x_r}) - $signed({old[15], old}));

  sdft_ram #(.WIDTH(16), .DEPTH(WINDOW_LENGTH)) u_delay (
    .clk(clk), .we(pend), .waddr(pos), .wdata(x_r), .raddr(pos), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      dl_valid <= '0;
      pend     <= 1'b0;
    end else begin
      pend <= accept;
      if (pend) begin
        dl_valid[pos] <= 1'b1;
        pos <= (pos == AW'(WINDOW_LENGTH - 1)) ? '0 : pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) x_r <= sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case ({pend, pop})
        2'b01: begin
          q0    <= q1;
          count <= count - 1'b1;
        end
        2'b10: begin
          if (count == 2'd0) q0 <= d;
          else q1 <= d;
          count <= count + 1'b1;
        end
        2'b11: begin
          if (count == 2'd1) begin
            q0 <= d;
          end else begin
            q0 <= q1;
            q1 <= d;
          end
        end
        default: ;
      endcase
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.diff  = q0;
endmodule

FILE: rtl/sdft_isqrt.sv
// Iterative integer square root of a 64-bit value, giving a 32-bit root.
// No dependencies.
module sdft_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);
  logic        busy;
  logic [63:0] v, res, bitv, trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && bitv[0]) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= operand;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end
endmodule

FILE: rtl/sdft_back.sv
// Back end: updates each bin in turn (leak, rotate, magnitude, floor, peak)
// and drives the result register. Depends on sdft_pkg, sdft_ram, sdft_isqrt.
module sdft_back import sdft_pkg::*; #(
  parameter int WINDOW_LENGTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  sdft_cfg_t   cfg,
  input  sdft_queue_t head,
  output logic        pop,
  output logic [5:0]  bin_index,
  output logic [31:0] magnitude,
  output logic [31:0] noise_level,
  output logic [31:0] peak_level,
  output logic        last_bin,
  output logic        out_valid,
  input  logic        out_stall
);
  localparam int NUM_BINS = WINDOW_LENGTH / 2;
  localparam int BW       = $clog2(NUM_BINS);
  localparam int SW       = 136;

  sdft_state_t state, state_next;

  logic signed [15:0] tw_cos [NUM_BINS];
  logic signed [15:0] tw_sin [NUM_BINS];

  for (genvar g = 0; g < NUM_BINS; g++) begin : g_tw
    assign tw_cos[g] = sdft_twiddle(g, WINDOW_LENGTH, 1'b0);
    assign tw_sin[g] = sdft_twiddle(g, WINDOW_LENGTH, 1'b1);
  end

  logic [BW-1:0]       bin;
  logic [NUM_BINS-1:0] bin_valid;
  logic                last;
  logic [16:0]         d_r;
  logic signed [15:0]  twc, tws;
  logic [SW-1:0]       rdata, wdata, st;
  logic                ram_we, sqrt_start, sqrt_done, emit, slot_free;
  logic signed [49:0]  p_ar, p_ai;
  logic signed [33:0]  ar, ai;
  logic signed [49:0]  m_rc, m_is, m_rs, m_ic;
  logic signed [31:0]  re_n, im_n;
  logic signed [63:0]  sq_re, sq_im;
  logic [31:0]         mag, root, fl_r, pk_r, fl_new, pk_new;
  logic [7:0]          hold_r, hold_n;
  logic                newpk;
  logic signed [49:0]  fl_prod;
  logic [47:0]         pk_prod;
  logic signed [32:0]  fdiff;
  logic signed [33:0]  fl_step;

  assign last      = (bin == BW'(NUM_BINS - 1));
  assign slot_free = !out_valid || !out_stall;
  assign st        = bin_valid[bin] ? rdata : '0;
  assign fdiff     = $signed({1'b0, mag}) - $signed({1'b0, fl_r});
  assign fl_step   = 34'((fl_prod + 50'sd32768) >>> 16);
  assign fl_new    = fl_r + fl_step[31:0];
  assign pk_new    = newpk ? mag :
                     (hold_n > 8'(WINDOW_LENGTH)) ? pk_prod[47:16] : pk_r;
  assign wdata     = {hold_n, pk_new, fl_new, im_n, re_n};

  sdft_ram #(.WIDTH(SW), .DEPTH(NUM_BINS)) u_bins (
    .clk(clk), .we(ram_we), .waddr(bin), .wdata(wdata), .raddr(bin), .rdata(rdata)
  );

  sdft_isqrt u_root (
    .clk(clk), .rst(rst), .start(sqrt_start),
    .operand(64'(sq_re) + 64'(sq_im)), .done(sqrt_done), .root(root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (head.valid) state_next = ST_READ;
      ST_READ:   state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_ROT;
      ST_ROT:    state_next = ST_SAT;
      ST_SAT:    state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM:    state_next = ST_ROOT;
      ST_ROOT:   if (sqrt_done) state_next = ST_TRACK;
      ST_TRACK:  state_next = ST_EMIT;
      ST_EMIT:   if (slot_free) state_next = last ? ST_IDLE : ST_READ;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = (state == ST_IDLE) && head.valid;
    sqrt_start = (state == ST_SUM);
    emit       = (state == ST_EMIT) && slot_free;
    ram_we     = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bin       <= '0;
      bin_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) bin <= '0;
      if (emit) begin
        bin_valid[bin] <= 1'b1;
        if (!last) bin <= bin + 1'b1;
      end
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) d_r <= head.diff;
    if (state == ST_READ) begin
      twc <= tw_cos[bin];
      tws <= tw_sin[bin];
    end
    if (state == ST_LOAD) begin
      p_ar   <= $signed({st[31], st[31:0]} + {{16{d_r[16]}}, d_r})
                * $signed({1'b0, cfg.stability});
      p_ai   <= $signed(st[63:32]) * $signed({1'b0, cfg.stability});
      fl_r   <= st[95:64];
      pk_r   <= st[127:96];
      hold_r <= st[135:128];
    end
    if (state == ST_ROUND) begin
      ar <= 34'((p_ar + 50'sd32768) >>> 16);
      ai <= 34'((p_ai + 50'sd32768) >>> 16);
    end
    if (state == ST_ROT) begin
      m_rc <= ar * twc;
      m_is <= ai * tws;
      m_rs <= ar * tws;
      m_ic <= ai * twc;
    end
    if (state == ST_SAT) begin
      re_n <= sdft_sat32(($signed({m_rc[49], m_rc}) - $signed({m_is[49], m_is})
                          + 51'sd16384) >>> 15);
      im_n <= sdft_sat32(($signed({m_rs[49], m_rs}) + $signed({m_ic[49], m_ic})
                          + 51'sd16384) >>> 15);
    end
    if (state == ST_SQUARE) begin
      sq_re <= re_n * re_n;
      sq_im <= im_n * im_n;
    end
    if (state == ST_ROOT && sqrt_done) mag <= root;
    if (state == ST_TRACK) begin
      fl_prod <= fdiff * $signed({1'b0, (mag < fl_r) ? cfg.fall : cfg.rise});
      pk_prod <= pk_r * cfg.decay;
      newpk   <= mag > pk_r;
      hold_n  <= (mag > pk_r) ? 8'd0 : (hold_r == 8'hff) ? hold_r : hold_r + 1'b1;
    end
    if (emit) begin
      bin_index   <= 6'(bin);
      magnitude   <= mag;
      noise_level <= fl_new;
      peak_level  <= pk_new;
      last_bin    <= last;
    end
  end
endmodule

FILE: rtl/sliding_dft_bin_tracker.sv
// Top level of the sliding DFT bin tracker: configuration registers and the
// front/back split. Depends on sdft_pkg, sdft_front and sdft_back.
//
// Input channel: one signed 16-bit sample per item (in_valid / in_stall).
// Output channel: WINDOW_LENGTH/2 result items per sample, bins in order
// 0 upwards, last_bin high on the final one (out_valid / out_stall).
// Configuration: APB-style, registers at byte addresses 0, 4, 8, 12
// (stability, floor rise, floor fall, peak decay), low 16 bits kept.
// Write only while idle.
// Each bin's update is dominated by the iterative square root unit
// (32 steps); the bin engine finishes all bins of a sample before it
// takes the next one. A two-entry queue lets up to two samples wait
// while the bin engine works.
// Reset clears the delay line, all bins, floors, peaks and hold counters
// (through valid bits) and loads the default register values.
// A stalled output holds its item; the bin engine then waits.
module sliding_dft_bin_tracker import sdft_pkg::*; #(
  parameter int WINDOW_LENGTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic signed [15:0] sample,
  input  logic               in_valid,
  output logic               in_stall,
  output logic [5:0]         bin_index,
  output logic [31:0]        magnitude,
  output logic [31:0]        noise_level,
  output logic [31:0]        peak_level,
  output logic               last_bin,
  output logic               out_valid,
  input  logic               out_stall
);
  sdft_cfg_t   cfg;
  sdft_queue_t head;
  logic        pop;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stability <= RST_STABILITY;
      cfg.rise      <= RST_RISE;
      cfg.fall      <= RST_FALL;
      cfg.decay     <= RST_DECAY;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_STABILITY: cfg.stability <= pwdata[15:0];
        REG_RISE:      cfg.rise      <= pwdata[15:0];
        REG_FALL:      cfg.fall      <= pwdata[15:0];
        REG_DECAY:     cfg.decay     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STABILITY: prdata = {16'd0, cfg.stability};
      REG_RISE:      prdata = {16'd0, cfg.rise};
      REG_FALL:      prdata = {16'd0, cfg.fall};
      REG_DECAY:     prdata = {16'd0, cfg.decay};
      default:       prdata = '0;
    endcase
  end

  sdft_front #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_front (
    .clk(clk), .rst(rst), .sample(sample), .in_valid(in_valid),
    .in_stall(in_stall), .pop(pop), .head(head)
  );

  sdft_back #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head(head), .pop(pop),
    .bin_index(bin_index), .magnitude(magnitude), .noise_level(noise_level),
    .peak_level(peak_level), .last_bin(last_bin), .out_valid(out_valid),
    .out_stall(out_stall)
  );
endmodule
